// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the date-to-seconds block.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UDTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("udtt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UDTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("udtt assertion failed");

`endif

// ===== rtl/udtt_pkg.sv =====
// Shared types, widths, constants and the month table of the date-to-seconds block.
// Depends on nothing.
`default_nettype none

package udtt_pkg;

  // Field widths.
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TtW    = 45;

  // Internal widths.
  localparam int unsigned YOffW  = 12;   // years since the base year
  localparam int unsigned ElapW  = 4;    // elapsed months, 0 .. 12
  localparam int unsigned CentW  = 6;    // centuries, at most 41
  localparam int unsigned DaysW  = 21;   // whole days before the date
  localparam int unsigned TodW   = 34;   // signed time of day in ms
  localparam int unsigned DbmW   = 9;    // days before a month
  localparam int unsigned RecipW = 17;   // reciprocal of 100, scaled
  localparam int unsigned RecipShift = 22;

  // Calendar and time constants.
  localparam int unsigned BaseYear        = 2000;
  localparam int unsigned YearSpanDefault = 400;
  localparam int unsigned Recip100        = 41944;  // ceil(2^22 / 100)
  localparam longint unsigned MsPerDay    = 86400000;
  localparam longint unsigned MsPerHour   = 3600000;
  localparam longint unsigned MsPerMinute = 60000;
  localparam longint unsigned EpochOffsetMs = 43135816;

  // Fields of one request after the input register.
  typedef struct packed {
    logic [YOffW-1:0] y_off;
    logic [ElapW-1:0] elapsed;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [MsW-1:0]   ms;
  } udtt_item_t;

  // Control that travels with a request through the pipeline.
  typedef struct packed {
    logic valid;
    logic oor;
  } udtt_ctl_t;

  // Days before the start of a month in a common year, by elapsed months.
  function automatic logic [DbmW-1:0] days_before_month(input logic [ElapW-1:0] e);
    logic [DbmW-1:0] d;
    case (e)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utc_date_to_tt_seconds.sv =====
// Top level of the calendar-date to milliseconds-since-epoch converter.
// Depends on udtt_pkg, udtt_front, udtt_days, udtt_scale and assert_macros.svh.
//
// Usage: drive the date fields on in_* and raise start for one cycle per
// request. A request is taken at each rising edge where start is high and
// busy is low; busy never rises, so a new request may come every cycle.
// Each request yields exactly one result: out_valid is high for one cycle
// with out_tt_ms and out_out_of_range.
// Throughput is one request per cycle, set by a four-register pipeline
// (input, century and time of day, day count, scaling by the milliseconds
// of a day).
// Years outside the supported span give out_out_of_range high and zero ms.
// The receiver cannot stall; results must be taken when out_valid is high.
// Reset (rst_n low, synchronous) clears all valid bits, so nothing in
// flight comes out afterwards.
`default_nettype none
`include "assert_macros.svh"

module utc_date_to_tt_seconds #(
  parameter int unsigned YEAR_SPAN = udtt_pkg::YearSpanDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [udtt_pkg::YearW-1:0]        in_year,
  input  wire logic [udtt_pkg::MonthW-1:0]       in_month,
  input  wire logic [udtt_pkg::DayW-1:0]         in_day,
  input  wire logic [udtt_pkg::HourW-1:0]        in_hour,
  input  wire logic [udtt_pkg::MinW-1:0]         in_minute,
  input  wire logic [udtt_pkg::MsW-1:0]          in_millisecond,
  output logic                                   out_valid,
  output logic signed [udtt_pkg::TtW-1:0]        out_tt_ms,
  output logic                                   out_out_of_range
);

  localparam int unsigned CmpW = udtt_pkg::YearW + 1;

  udtt_pkg::udtt_ctl_t               ctl_a, ctl_c;
  udtt_pkg::udtt_item_t              item_a;
  logic [udtt_pkg::DaysW-1:0]        days_c;
  logic signed [udtt_pkg::TodW-1:0]  tod_c;
  logic                              accept;

  // The pipeline takes a request every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  udtt_front #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .year        (in_year),
    .month       (in_month),
    .day         (in_day),
    .hour        (in_hour),
    .minute      (in_minute),
    .millisecond (in_millisecond),
    .ctl_o       (ctl_a),
    .item_o      (item_a)
  );

  udtt_days u_days (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_a),
    .item_i (item_a),
    .ctl_o  (ctl_c),
    .days_o (days_c),
    .tod_o  (tod_c)
  );

  udtt_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_c),
    .days_i   (days_c),
    .tod_i    (tod_c),
    .valid_o  (out_valid),
    .tt_ms_o  (out_tt_ms),
    .oor_o    (out_out_of_range)
  );

  // A result only follows an earlier request.
  `UDTT_ASSERT_NOW(a_result_has_request, clk, rst_n, out_valid, $past(start, 4))
  // An out-of-range result carries zero milliseconds.
  `UDTT_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_out_of_range, out_tt_ms == '0)
  // The range flag matches the year of the request that caused it.
  `UDTT_ASSERT_NOW(a_oor_matches_year, clk, rst_n, out_valid,
    out_out_of_range == ((CmpW'($past(in_year, 4)) < CmpW'(udtt_pkg::BaseYear)) ||
                         (CmpW'($past(in_year, 4)) >= CmpW'(udtt_pkg::BaseYear + YEAR_SPAN))))

endmodule

`default_nettype wire

// ===== rtl/udtt_front.sv =====
// Input register of the date-to-seconds block: range check and month clamp.
// Depends on udtt_pkg.
`default_nettype none

module udtt_front #(
  parameter int unsigned YEAR_SPAN = udtt_pkg::YearSpanDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [udtt_pkg::YearW-1:0]    year,
  input  wire logic [udtt_pkg::MonthW-1:0]   month,
  input  wire logic [udtt_pkg::DayW-1:0]     day,
  input  wire logic [udtt_pkg::HourW-1:0]    hour,
  input  wire logic [udtt_pkg::MinW-1:0]     minute,
  input  wire logic [udtt_pkg::MsW-1:0]      millisecond,
  output udtt_pkg::udtt_ctl_t                ctl_o,
  output udtt_pkg::udtt_item_t               item_o
);

  localparam int unsigned CmpW = udtt_pkg::YearW + 1;
  localparam logic [CmpW-1:0] LimLo = CmpW'(udtt_pkg::BaseYear);
  localparam logic [CmpW-1:0] LimHi = CmpW'(udtt_pkg::BaseYear + YEAR_SPAN);

  udtt_pkg::udtt_ctl_t  ctl_r, ctl_nxt;
  udtt_pkg::udtt_item_t item_r, item_nxt;
  logic [CmpW-1:0]      year_ext;

  // Year span check and clamping of the elapsed month count.
  always_comb begin
    year_ext       = CmpW'(year);
    ctl_nxt.valid  = accept;
    ctl_nxt.oor    = (year_ext < LimLo) || (year_ext >= LimHi);
    item_nxt.y_off = udtt_pkg::YOffW'(year - udtt_pkg::YearW'(udtt_pkg::BaseYear));
    if (month == '0) begin
      item_nxt.elapsed = '0;
    end else if (month > 4'd13) begin
      item_nxt.elapsed = 4'd12;
    end else begin
      item_nxt.elapsed = month - 4'd1;
    end
    item_nxt.day    = day;
    item_nxt.hour   = hour;
    item_nxt.minute = minute;
    item_nxt.ms     = millisecond;
  end

  // Input register; payload is loaded only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign item_o = item_r;

endmodule

`default_nettype wire

// ===== rtl/udtt_days.sv =====
// Day count of the date-to-seconds block: centuries by reciprocal, leap rule, month table.
// Depends on udtt_pkg.
`default_nettype none

module udtt_days (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  udtt_pkg::udtt_ctl_t                     ctl_i,
  input  udtt_pkg::udtt_item_t                    item_i,
  output udtt_pkg::udtt_ctl_t                     ctl_o,
  output logic [udtt_pkg::DaysW-1:0]              days_o,
  output logic signed [udtt_pkg::TodW-1:0]        tod_o
);

  localparam int unsigned VW = udtt_pkg::YOffW + 1;
  localparam int unsigned PW = VW + udtt_pkg::RecipW;
  localparam int unsigned TW = udtt_pkg::TodW;
  localparam int unsigned DW = udtt_pkg::DaysW;
  localparam int unsigned CW = udtt_pkg::CentW;
  localparam int unsigned RS = udtt_pkg::RecipShift;

  // Stage B signals.
  logic [VW-1:0]         v_c, v_d;
  logic [PW-1:0]         p_c, p_d;
  logic [CW-1:0]         cent_nxt, cent_r;      // ceil(y / 100)
  logic                  div100_nxt, div100_r;  // y is a multiple of 100
  logic signed [TW-1:0]  tod_nxt, tod_r;
  logic [udtt_pkg::YOffW-1:0] y_r;
  logic [udtt_pkg::ElapW-1:0] elap_r;
  udtt_pkg::udtt_ctl_t   ctl_b_r;

  // Stage C signals.
  logic                  leap;
  logic [DW-1:0]         days_nxt, days_r;
  logic signed [TW-1:0]  tod_c_r;
  udtt_pkg::udtt_ctl_t   ctl_c_r;

  // Centuries by multiplying with a scaled reciprocal of 100; exact for these widths.
  // floor((y+99)/100) and floor((y+100)/100) differ exactly when y is a multiple of 100.
  always_comb begin
    v_c        = VW'(item_i.y_off) + VW'(99);
    v_d        = VW'(item_i.y_off) + VW'(100);
    p_c        = PW'(v_c) * PW'(udtt_pkg::Recip100);
    p_d        = PW'(v_d) * PW'(udtt_pkg::Recip100);
    cent_nxt   = p_c[RS +: CW];
    div100_nxt = (p_d[RS +: CW] != p_c[RS +: CW]);
  end

  // Time of day; a day of zero subtracts one whole day of milliseconds.
  always_comb begin
    tod_nxt = $signed(TW'(item_i.ms))
            + $signed(TW'(item_i.minute)) * $signed(TW'(udtt_pkg::MsPerMinute))
            + $signed(TW'(item_i.hour)) * $signed(TW'(udtt_pkg::MsPerHour))
            + ($signed(TW'(item_i.day)) - $signed(TW'(1)))
              * $signed(TW'(udtt_pkg::MsPerDay));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else begin
      ctl_b_r <= ctl_i;
    end
    cent_r   <= cent_nxt;
    div100_r <= div100_nxt;
    tod_r    <= tod_nxt;
    y_r      <= item_i.y_off;
    elap_r   <= item_i.elapsed;
  end

  // Gregorian leap rule on years since 2000 and the whole-day count.
  always_comb begin
    leap = (y_r[1:0] == 2'b00) && (!div100_r || (cent_r[1:0] == 2'b00));
    days_nxt = DW'(y_r) * DW'(365)
             + DW'((DW'(y_r) + DW'(3)) >> 2)
             - DW'(cent_r)
             + DW'((DW'(cent_r) + DW'(3)) >> 2)
             + DW'(udtt_pkg::days_before_month(elap_r))
             + DW'(leap && (elap_r >= 4'd2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else begin
      ctl_c_r <= ctl_b_r;
    end
    days_r  <= days_nxt;
    tod_c_r <= tod_r;
  end

  assign ctl_o  = ctl_c_r;
  assign days_o = days_r;
  assign tod_o  = tod_c_r;

endmodule

`default_nettype wire

// ===== rtl/udtt_scale.sv =====
// Output stage of the date-to-seconds block: days to milliseconds, offset, result register.
// Depends on udtt_pkg.
`default_nettype none

module udtt_scale (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  udtt_pkg::udtt_ctl_t                     ctl_i,
  input  wire logic [udtt_pkg::DaysW-1:0]         days_i,
  input  wire logic signed [udtt_pkg::TodW-1:0]   tod_i,
  output logic                                    valid_o,
  output logic signed [udtt_pkg::TtW-1:0]         tt_ms_o,
  output logic                                    oor_o
);

  localparam int unsigned TW = udtt_pkg::TtW;
  localparam int unsigned MW = udtt_pkg::DaysW + 27;

  logic [MW-1:0]          prod;
  logic [TW-1:0]          tt_nxt, tt_r;
  logic                   valid_r, oor_r;

  // Scale days to ms, add time of day, subtract epoch offset, wrap to width; zero if oor.
  always_comb begin
    prod   = MW'(days_i) * MW'(udtt_pkg::MsPerDay);
    tt_nxt = TW'(prod) + TW'(tod_i) - TW'(udtt_pkg::EpochOffsetMs);
    if (ctl_i.oor) begin
      tt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
    oor_r <= ctl_i.oor;
    tt_r  <= tt_nxt;
  end

  assign valid_o = valid_r;
  assign oor_o   = oor_r;
  assign tt_ms_o = $signed(tt_r);

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for utc_date_to_tt_seconds: dates go in, predicted millisecond counts
// are compared with each strobed result. Depends on udtt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned YearW  = udtt_pkg::YearW;
  localparam int unsigned MonthW = udtt_pkg::MonthW;
  localparam int unsigned DayW   = udtt_pkg::DayW;
  localparam int unsigned HourW  = udtt_pkg::HourW;
  localparam int unsigned MinW   = udtt_pkg::MinW;
  localparam int unsigned MsW    = udtt_pkg::MsW;
  localparam int unsigned TtW    = udtt_pkg::TtW;

  localparam int unsigned FirstYear   = udtt_pkg::BaseYear;
  localparam int unsigned SpanYears   = udtt_pkg::YearSpanDefault;
  localparam longint      DayMs       = 64'd86400000;
  localparam longint      HourMs      = 64'd3600000;
  localparam longint      MinuteMs    = 64'd60000;
  localparam longint      OffsetMs    = 64'd43135816;
  localparam int          RandomDates = 450;
  localparam int          DrainLimit  = 200;
  localparam int          SettleTicks = 8;

  typedef struct packed {
    logic signed [TtW-1:0] tt_ms;
    logic                  oor;
  } tt_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [YearW-1:0]      in_year;
  logic [MonthW-1:0]     in_month;
  logic [DayW-1:0]       in_day;
  logic [HourW-1:0]      in_hour;
  logic [MinW-1:0]       in_minute;
  logic [MsW-1:0]        in_millisecond;
  logic                  out_valid;
  logic signed [TtW-1:0] out_tt_ms;
  logic                  out_out_of_range;

  tt_result_t pending_times[$];
  int         mismatch_count = 0;
  bit         burst_mode = 1'b0;

  utc_date_to_tt_seconds dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_millisecond   (in_millisecond),
    .out_valid        (out_valid),
    .out_tt_ms        (out_tt_ms),
    .out_out_of_range (out_out_of_range)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Gregorian leap rule.
  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Length of month k (1 = January) for a common or leap year.
  function automatic int month_length(input int k, input bit leap);
    case (k)
      2:              return 28 + int'(leap);
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Expected millisecond count for one date. Months past December count as the
  // whole year; day, hour, minute and milliseconds are taken linearly.
  function automatic tt_result_t predict_tt_ms(input logic [YearW-1:0] year,
                                               input logic [MonthW-1:0] month,
                                               input logic [DayW-1:0] day,
                                               input logic [HourW-1:0] hour,
                                               input logic [MinW-1:0] minute,
                                               input logic [MsW-1:0] msec);
    tt_result_t r;
    longint     y;
    longint     days;
    longint     total;
    int         elapsed;
    r.tt_ms = '0;
    r.oor   = 1'b0;
    if (int'(year) < FirstYear || int'(year) >= FirstYear + SpanYears) begin
      r.oor = 1'b1;
      return r;
    end
    y    = longint'(year) - longint'(FirstYear);
    days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    elapsed = (month == 0) ? 0 : int'(month) - 1;
    if (elapsed > 12) elapsed = 12;
    for (int k = 1; k <= elapsed; k++) begin
      days += month_length(k, is_leap_year(year));
    end
    total = longint'(msec) + MinuteMs * longint'(minute) + HourMs * longint'(hour)
          + DayMs * (longint'(day) - 1) + DayMs * days - OffsetMs;
    r.tt_ms = total[TtW-1:0];
    return r;
  endfunction

  // Scoreboard: record each accepted request, then check any result in this cycle.
  always @(posedge clk) begin
    tt_result_t want;
    if (rst_n) begin
      if (start && !busy) begin
        pending_times.push_back(predict_tt_ms(in_year, in_month, in_day, in_hour,
                                              in_minute, in_millisecond));
      end
      if (out_valid) begin
        if (pending_times.size() == 0) begin
          $error("unexpected result: out_tt_ms %0d, out_out_of_range %0b",
                 out_tt_ms, out_out_of_range);
          mismatch_count++;
        end else begin
          want = pending_times.pop_front();
          if (out_tt_ms !== want.tt_ms) begin
            $error("out_tt_ms: expected %0d, actual %0d", want.tt_ms, out_tt_ms);
            mismatch_count++;
          end
          if (out_out_of_range !== want.oor) begin
            $error("out_out_of_range: expected %0b, actual %0b", want.oor,
                   out_out_of_range);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Idle time after a request: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  task automatic send_date(input logic [YearW-1:0] year, input logic [MonthW-1:0] month,
                           input logic [DayW-1:0] day, input logic [HourW-1:0] hour,
                           input logic [MinW-1:0] minute, input logic [MsW-1:0] msec);
    int gap;
    @(negedge clk);
    start          <= 1'b1;
    in_year        <= year;
    in_month       <= month;
    in_day         <= day;
    in_hour        <= hour;
    in_minute      <= minute;
    in_millisecond <= msec;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every outstanding request has produced its result, or DrainLimit is reached.
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_times.size() > 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleTicks) @(posedge clk);
  endtask

  // Corners of every field, the base date itself and the leap-day boundaries.
  task automatic test_field_extremes();
    send_date(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2399, 4'd12, 5'd31, 5'd23, 6'd59, 16'd59999);
    send_date(12'd2399, 4'hF, 5'h1F, 5'h1F, 6'h3F, 16'hFFFF);
    send_date(12'd2000, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
    send_date(12'd2001, 4'd13, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2000, 4'd13, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2000, 4'd2, 5'd29, 5'd12, 6'd30, 16'd30000);
    send_date(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2004, 4'd3, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2200, 4'd2, 5'd0, 5'd0, 6'd0, 16'd0);
    send_date(12'd2300, 4'd12, 5'd31, 5'd0, 6'd0, 16'd1);
    send_date(12'd2001, 4'd1, 5'd0, 5'd0, 6'd0, 16'd0);
    send_date(12'd2050, 4'd6, 5'd15, 5'd31, 6'd63, 16'd65535);
  endtask

  // Years on both sides of the supported span, some with other fields at their top.
  task automatic test_out_of_range_years();
    send_date(12'd0, 4'hF, 5'h1F, 5'h1F, 6'h3F, 16'hFFFF);
    send_date(12'd1999, 4'd1, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'd2400, 4'd1, 5'd1, 5'd0, 6'd0, 16'd0);
    send_date(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 16'hFFFF);
    drain_pipeline();
  endtask

  // Random dates: mostly well-formed, some with raw field values, some with any year.
  task automatic test_random_dates();
    int          roll;
    logic [11:0] year;
    for (int i = 0; i < RandomDates; i++) begin
      burst_mode = ((i % 90) >= 65);
      if (i == RandomDates / 2) drain_pipeline();
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        send_date(12'($urandom_range(FirstYear, FirstYear + SpanYears - 1)),
                  4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                  5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                  16'($urandom_range(0, 59999)));
      end else begin
        if (roll < 90) year = 12'($urandom_range(FirstYear, FirstYear + SpanYears - 1));
        else year = 12'($urandom_range(0, 4095));
        send_date(year, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                  16'($urandom_range(0, 65535)));
      end
    end
    burst_mode = 1'b0;
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_year        = '0;
    in_month       = '0;
    in_day         = '0;
    in_hour        = '0;
    in_minute      = '0;
    in_millisecond = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_out_of_range_years();
    test_random_dates();
    drain_pipeline();

    if (pending_times.size() != 0) begin
      $error("%0d expected results never arrived", pending_times.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
